FILE: src/bfba_pkg.sv
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared types, field widths, codes and helpers of the best-fit allocator.
// ----------------------------------------------------------------------------
package bfba_pkg;

	// Field widths of the request and response transactions
	localparam int unsigned FUNC_W       = 1;
	localparam int unsigned INDEX_W      = 4;
	localparam int unsigned SIZE_VALUE_W = 16;
	localparam int unsigned STATUS_W     = 2;

	// Configuration register
	localparam int unsigned COUNT_W      = 5;
	localparam int unsigned APB_ADDR_W   = 3;
	localparam int unsigned APB_DATA_W   = 32;
	localparam logic [APB_ADDR_W-3:0] REG_BLOCK_COUNT = '0;
	localparam logic [COUNT_W-1:0]    COUNT_RESET     = 5'd16;

	// Defaults of the top-level parameters
	localparam int unsigned DEF_NUM_BLOCKS = 16;
	localparam int unsigned DEF_SIZE_WIDTH = 16;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

	// Response status codes
	localparam logic [STATUS_W-1:0] STATUS_LOADED = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ALLOC  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_FIT = 2'd2;

	// Controller -> datapath
	typedef struct packed {
		logic capture;     // latch request fields
		logic scan_start;  // clear scan pointer and best candidate
		logic scan_rd;     // read entry at scan pointer, advance pointer
		logic wb;          // write back table entry, load response register
	} bfba_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic is_alloc;    // captured request is an allocate
		logic scan_done;   // every entry in use has been read
	} bfba_sts_t;

	// Index width for a table of n entries (at least one bit)
	function automatic int unsigned idx_w(input int unsigned n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

FILE: src/bfba_if.sv
// ----------------------------------------------------------------------------
// bfba_req_if / bfba_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface bfba_req_if import bfba_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [FUNC_W-1:0]       func;
	logic [INDEX_W-1:0]      load_index;
	logic [SIZE_VALUE_W-1:0] size_value;

	modport source (output valid, func, load_index, size_value, input ready);
	modport sink   (input valid, func, load_index, size_value, output ready);
endinterface

interface bfba_rsp_if import bfba_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic [INDEX_W-1:0]      chosen_block;
	logic [SIZE_VALUE_W-1:0] remaining_size;

	modport source (output valid, status, chosen_block, remaining_size, input ready);
	modport sink   (input valid, status, chosen_block, remaining_size, output ready);
endinterface

FILE: src/best_fit_block_allocator.sv
// Sequence: a load goes IDLE -> SCAN -> WRITE_BACK; an allocate reads
//   N = min(block_count, NUM_BLOCKS) entries in SCAN, one table read per cycle.
// Throughput: one transaction at a time; the next request is accepted once
//   the previous one is written back (response may still be waiting).
// Reset: arst_n clears the table (valid bits), block_count to 16, no response.
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator over a table of block free sizes, APB-configured count.
// ----------------------------------------------------------------------------
module best_fit_block_allocator import bfba_pkg::*; #(
	parameter int unsigned NUM_BLOCKS = DEF_NUM_BLOCKS,  // 1 .. 16
	parameter int unsigned SIZE_WIDTH = DEF_SIZE_WIDTH   // 4 .. 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// transaction channels
	bfba_req_if.sink              req,
	bfba_rsp_if.source            rsp
);

	// ------------------------------------------------------------------
	// Configuration register: block_count at byte address 0.
	// Low address bits are ignored; only the word index is decoded.
	// ------------------------------------------------------------------
	logic [COUNT_W-1:0] block_count_q;
	logic               cfg_wr;
	logic               sel_count;

	assign pready    = 1'b1;
	assign sel_count = (paddr[APB_ADDR_W-1:2] == REG_BLOCK_COUNT);
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign prdata    = sel_count ? APB_DATA_W'(block_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= COUNT_RESET;
		end else if (cfg_wr && sel_count) begin
			block_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Controller and datapath.
	// Controller: IDLE -> SCAN (allocate reads one entry per cycle) ->
	// WRITE_BACK (waits for a free response register). The datapath holds
	// the table in RAM with per-entry valid bits so reset needs no sweep.
	// ------------------------------------------------------------------
	bfba_cmd_t cmd;
	bfba_sts_t sts;

	bfba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bfba_dp #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.SIZE_WIDTH (SIZE_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.block_count    (block_count_q),
		.func           (req.func),
		.load_index     (req.load_index),
		.size_value     (req.size_value),
		.status         (rsp.status),
		.chosen_block   (rsp.chosen_block),
		.remaining_size (rsp.remaining_size)
	);

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
`ifndef ASSERT_OFF
	// one transaction in flight: ready drops after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while another transaction in flight");

	// a failed allocation reports zero index and zero size
	a_no_fit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == STATUS_NO_FIT) |->
			(rsp.chosen_block == '0) && (rsp.remaining_size == '0))
		else $error("not-allocated response carries nonzero fields");

	// a response appears only after a write-back
	a_rsp_after_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.wb))
		else $error("response raised without write-back");

	// no table read in the same cycle as a write-back or an accept
	a_rd_wb_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |-> !cmd.wb && !req.ready)
		else $error("scan read overlaps write-back or accept");
`endif

endmodule

FILE: src/bfba_ram.sv
// ----------------------------------------------------------------------------
// bfba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfba_ram import bfba_pkg::*; #(
	parameter int unsigned WIDTH = DEF_SIZE_WIDTH,
	parameter int unsigned DEPTH = DEF_NUM_BLOCKS
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [idx_w(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]        wdata,
	input  logic                    re,
	input  logic [idx_w(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/bfba_ctrl.sv
// ----------------------------------------------------------------------------
// bfba_ctrl
// Sequencer: accept, scan the table one entry per cycle for an allocate, write back, respond.
// ----------------------------------------------------------------------------
module bfba_ctrl import bfba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  bfba_sts_t sts,
	output bfba_cmd_t cmd
);

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		WRITE_BACK
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// response register can take a new transaction this cycle
	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			IDLE: begin
				cmd.capture    = req_valid;
				cmd.scan_start = req_valid;
			end
			SCAN: begin
				cmd.scan_rd = !sts.scan_done;
			end
			WRITE_BACK: begin
				cmd.wb = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wb) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (req_valid) begin
						state_q <= SCAN;
					end
				end
				SCAN: begin
					// loads skip the search
					if (!sts.is_alloc || sts.scan_done) begin
						state_q <= WRITE_BACK;
					end
				end
				WRITE_BACK: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/bfba_dp.sv
// ----------------------------------------------------------------------------
// bfba_dp
// Free-size table, scan pointer, best-candidate tracker and response register.
// ----------------------------------------------------------------------------
module bfba_dp import bfba_pkg::*; #(
	parameter int unsigned NUM_BLOCKS = DEF_NUM_BLOCKS,
	parameter int unsigned SIZE_WIDTH = DEF_SIZE_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bfba_cmd_t               cmd,
	output bfba_sts_t               sts,
	input  logic [COUNT_W-1:0]      block_count,
	input  logic [FUNC_W-1:0]       func,
	input  logic [INDEX_W-1:0]      load_index,
	input  logic [SIZE_VALUE_W-1:0] size_value,
	output logic [STATUS_W-1:0]     status,
	output logic [INDEX_W-1:0]      chosen_block,
	output logic [SIZE_VALUE_W-1:0] remaining_size
);

	localparam int unsigned IDX_W = idx_w(NUM_BLOCKS);
	localparam int unsigned CNT_W = idx_w(NUM_BLOCKS + 1);

	// captured request
	logic [FUNC_W-1:0]     func_q;
	logic [INDEX_W-1:0]    index_q;
	logic [SIZE_WIDTH-1:0] size_q;

	// scan
	logic [CNT_W-1:0]      ptr_q;
	logic [CNT_W-1:0]      active_n;
	logic                  rd_s1;
	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [SIZE_WIDTH-1:0] rdata;
	logic [SIZE_WIDTH-1:0] entry_val;
	logic                  hit;

	// best candidate
	logic                  found_q;
	logic [SIZE_WIDTH-1:0] best_val_q;
	logic [IDX_W-1:0]      best_idx_q;

	// table
	logic [NUM_BLOCKS-1:0] vld_q;
	logic                  in_range;
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [SIZE_WIDTH-1:0] ram_wdata;
	logic [SIZE_WIDTH-1:0] alloc_left;

	assign active_n = (32'(block_count) > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
	                                                        : CNT_W'(block_count);

	assign sts.is_alloc  = (func_q == FUNC_ALLOC);
	assign sts.scan_done = (ptr_q == active_n);

	// never-written entries read as zero
	assign entry_val = vld_s1 ? rdata : '0;
	assign hit       = rd_s1 && (entry_val >= size_q) && (!found_q || entry_val < best_val_q);

	assign in_range   = 32'(index_q) < 32'(NUM_BLOCKS);
	assign alloc_left = best_val_q - size_q;
	assign ram_we     = cmd.wb && (sts.is_alloc ? found_q : in_range);
	assign ram_waddr  = sts.is_alloc ? best_idx_q : IDX_W'(index_q);
	assign ram_wdata  = sts.is_alloc ? alloc_left : size_q;

	bfba_ram #(
		.WIDTH (SIZE_WIDTH),
		.DEPTH (NUM_BLOCKS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.scan_rd),
		.raddr (ptr_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rd_s1   <= 1'b0;
			found_q <= 1'b0;
			ptr_q   <= '0;
		end else begin
			rd_s1 <= cmd.scan_rd;
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (cmd.scan_start) begin
				ptr_q <= '0;
			end else if (cmd.scan_rd) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (cmd.scan_start) begin
				found_q <= 1'b0;
			end else if (hit) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= func;
			index_q <= load_index;
			size_q  <= SIZE_WIDTH'(size_value);
		end
		if (cmd.scan_rd) begin
			vld_s1 <= vld_q[ptr_q[IDX_W-1:0]];
			idx_s1 <= ptr_q[IDX_W-1:0];
		end
		if (hit) begin
			best_val_q <= entry_val;
			best_idx_q <= idx_s1;
		end
		if (cmd.wb) begin
			if (!sts.is_alloc) begin
				status         <= STATUS_LOADED;
				chosen_block   <= index_q;
				remaining_size <= in_range ? SIZE_VALUE_W'(size_q) : '0;
			end else if (found_q) begin
				status         <= STATUS_ALLOC;
				chosen_block   <= INDEX_W'(best_idx_q);
				remaining_size <= SIZE_VALUE_W'(alloc_left);
			end else begin
				status         <= STATUS_NO_FIT;
				chosen_block   <= '0;
				remaining_size <= '0;
			end
		end
	end

endmodule

FILE: tb/tb_best_fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_block_allocator
// Self-checking bench for the best-fit allocator: loads and allocate requests
// go in on the request channel, and a local best-fit table predicts every
// response. Directed corner cases come first, then random refill/allocate
// traffic under several block_count settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_best_fit_block_allocator;
	import bfba_pkg::*;

	localparam int unsigned NUM_BLOCKS  = DEF_NUM_BLOCKS;
	localparam int unsigned SIZE_WIDTH  = DEF_SIZE_WIDTH;
	localparam int unsigned HOLD_CYCLES = 400;  // long response stall
	localparam int unsigned TAIL_CYCLES = 40;   // idle tail after the last response

	// One response transaction, field by field
	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic [INDEX_W-1:0]      chosen_block;
		logic [SIZE_VALUE_W-1:0] remaining_size;
	} alloc_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	bfba_req_if alloc_req ();
	bfba_rsp_if alloc_rsp ();

	best_fit_block_allocator #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.SIZE_WIDTH (SIZE_WIDTH)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (alloc_req),
		.rsp     (alloc_rsp)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// Local copy of the allocator: free size table and search count
	// ------------------------------------------------------------------------
	logic [SIZE_VALUE_W-1:0] free_size [NUM_BLOCKS];
	logic [COUNT_W-1:0]      count_setting;

	alloc_result_t pending_results [$];  // predicted, oldest first

	int unsigned mismatches;
	int unsigned items_sent;
	int unsigned n_loaded, n_allocated, n_no_fit;
	int unsigned config_writes;

	// idle percentages of the two sides, changed per phase
	int unsigned src_idle_pct;
	int unsigned sink_idle_pct;
	logic        rsp_hold = 1'b0;  // forces rsp ready low for a long stretch

	// Best-fit prediction of one transaction; updates the local table.
	// A load past the table writes nothing and reports a zero size.
	function automatic alloc_result_t predict_alloc(input logic [FUNC_W-1:0] func,
	                                                input logic [INDEX_W-1:0] index,
	                                                input logic [SIZE_VALUE_W-1:0] size);
		alloc_result_t res;
		int unsigned   active;
		int            best;
		res = '0;
		if (func == FUNC_LOAD) begin
			res.status       = STATUS_LOADED;
			res.chosen_block = index;
			if (32'(index) < NUM_BLOCKS) begin
				free_size[index]   = size;
				res.remaining_size = size;
			end
			return res;
		end
		// counts above the table size search the whole table
		active = (count_setting > NUM_BLOCKS) ? NUM_BLOCKS : count_setting;
		best   = -1;
		for (int j = 0; j < active; j++) begin
			// strict less-than keeps the lowest index on equal sizes
			if (free_size[j] >= size && (best < 0 || free_size[j] < free_size[best]))
				best = j;
		end
		if (best < 0) begin
			res.status = STATUS_NO_FIT;
		end else begin
			free_size[best]    = free_size[best] - size;
			res.status         = STATUS_ALLOC;
			res.chosen_block   = INDEX_W'(best);
			res.remaining_size = free_size[best];
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------------
	// Response side: random ready, checker against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (rsp_hold)
			alloc_rsp.ready <= 1'b0;
		else
			alloc_rsp.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		alloc_result_t want;
		if (alloc_rsp.valid && alloc_rsp.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected response status=%0d block=%0d size=%0d",
					alloc_rsp.status, alloc_rsp.chosen_block, alloc_rsp.remaining_size));
			end else begin
				want = pending_results.pop_front();
				if (alloc_rsp.status != want.status)
					report_mismatch($sformatf("status exp %0d got %0d",
						want.status, alloc_rsp.status));
				if (alloc_rsp.chosen_block != want.chosen_block)
					report_mismatch($sformatf("chosen_block exp %0d got %0d",
						want.chosen_block, alloc_rsp.chosen_block));
				if (alloc_rsp.remaining_size != want.remaining_size)
					report_mismatch($sformatf("remaining_size exp %0d got %0d",
						want.remaining_size, alloc_rsp.remaining_size));
				case (want.status)
					STATUS_LOADED: n_loaded++;
					STATUS_ALLOC:  n_allocated++;
					default:       n_no_fit++;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// valid stays high after a transaction so back-to-back items never see
	// two assignments in one step; stop_requests drops it before any wait
	task automatic send_item(input logic [FUNC_W-1:0] func,
	                         input logic [INDEX_W-1:0] index,
	                         input logic [SIZE_VALUE_W-1:0] size);
		while ($urandom_range(99) < src_idle_pct) begin
			alloc_req.valid <= 1'b0;
			@(posedge clk);
		end
		alloc_req.valid      <= 1'b1;
		alloc_req.func       <= func;
		alloc_req.load_index <= index;
		alloc_req.size_value <= size;
		do @(posedge clk); while (!alloc_req.ready);
		pending_results.push_back(predict_alloc(func, index, size));
		items_sent++;
	endtask

	task automatic stop_requests();
		alloc_req.valid <= 1'b0;
		@(posedge clk);
	endtask

	// every transaction yields one response, so an empty queue means idle
	task automatic wait_drained();
		stop_requests();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// APB write of block_count while idle, then read it back
	task automatic set_block_count(input logic [COUNT_W-1:0] value);
		wait_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_BLOCK_COUNT, 2'b00};
		pwdata  <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		count_setting = value;
		config_writes++;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[COUNT_W-1:0] !== value)
			report_mismatch($sformatf("block_count readback exp %0d got %0d",
				value, prdata[COUNT_W-1:0]));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// load sizes: zeros, full scale, duplicates of other entries (ties), small, random
	function automatic logic [SIZE_VALUE_W-1:0] pick_load_size();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return free_size[$urandom_range(NUM_BLOCKS-1)];
			3, 4, 5: return SIZE_VALUE_W'($urandom_range(4095));
			default: return SIZE_VALUE_W'($urandom);
		endcase
	endfunction

	// requests: exact fits, just under or over an entry, zero, full scale, small, random
	function automatic logic [SIZE_VALUE_W-1:0] pick_request_size();
		logic [SIZE_VALUE_W-1:0] base;
		base = free_size[$urandom_range(NUM_BLOCKS-1)];
		case ($urandom_range(11))
			0:       return '0;
			1:       return '1;
			2, 3:    return base;
			4, 5:    return (base > 16) ? base - SIZE_VALUE_W'($urandom_range(1, 16)) : base;
			6:       return base + 1'b1;
			7, 8:    return SIZE_VALUE_W'($urandom_range(255));
			default: return SIZE_VALUE_W'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// table is all zero after reset: a zero request fits entry 0, one does not
	task automatic test_empty_table();
		send_item(FUNC_ALLOC, 4'd9, '0);
		send_item(FUNC_ALLOC, 4'd0, 16'd1);
	endtask

	task automatic test_field_extremes();
		send_item(FUNC_LOAD,  4'd15, '1);
		send_item(FUNC_LOAD,  4'd0,  16'd1);
		send_item(FUNC_ALLOC, 4'd15, '1);
		send_item(FUNC_ALLOC, 4'd0,  16'd1);
	endtask

	// two entries of equal size: lowest index wins, then an exact fit
	task automatic test_best_fit_ties();
		send_item(FUNC_LOAD,  4'd3,  16'd500);
		send_item(FUNC_LOAD,  4'd7,  16'd300);
		send_item(FUNC_LOAD,  4'd9,  16'd300);
		send_item(FUNC_LOAD,  4'd12, 16'd1000);
		send_item(FUNC_ALLOC, 4'd0,  16'd250);
		send_item(FUNC_ALLOC, 4'd0,  16'd300);
	endtask

	// count of zero never fits; a count past the table searches all of it
	task automatic test_count_limits();
		set_block_count(5'd0);
		send_item(FUNC_ALLOC, 4'd0, '0);
		set_block_count(5'd31);
		send_item(FUNC_ALLOC, 4'd0, 16'd400);
	endtask

	// an entry past the count is written but only found once the count grows
	task automatic test_load_beyond_count();
		set_block_count(5'd4);
		send_item(FUNC_LOAD,  4'd10, 16'd40000);
		send_item(FUNC_ALLOC, 4'd0,  16'd40000);
		set_block_count(5'd16);
		send_item(FUNC_ALLOC, 4'd0,  16'd40000);
	endtask

	// occasional refill bursts between allocate runs, with random content
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned sent;
		int unsigned run_len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(3) == 0) begin
				run_len = $urandom_range(1, 4);
				repeat (run_len) begin
					send_item(FUNC_LOAD, INDEX_W'($urandom_range(NUM_BLOCKS-1)),
						pick_load_size());
					sent++;
				end
			end
			run_len = $urandom_range(1, 4);
			repeat (run_len) begin
				send_item(FUNC_ALLOC, INDEX_W'($urandom_range(NUM_BLOCKS-1)),
					pick_request_size());
				sent++;
			end
		end
	endtask

	// receiver stops for a long stretch while requests keep coming,
	// so the response register fills and request ready drops
	task automatic test_output_backpressure();
		int unsigned saved_src;
		saved_src    = src_idle_pct;
		src_idle_pct = 0;
		fork
			begin
				rsp_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_hold <= 1'b0;
			end
		join_none
		test_random_traffic(24);
		src_idle_pct = saved_src;
	endtask

	// sender stops until every response is back, then resumes
	task automatic test_drain_pause();
		test_random_traffic(10);
		wait_drained();
		test_random_traffic(10);
	endtask

	initial begin
		alloc_req.valid      = 1'b0;
		alloc_req.func       = FUNC_LOAD;
		alloc_req.load_index = '0;
		alloc_req.size_value = '0;
		alloc_rsp.ready      = 1'b0;
		foreach (free_size[i]) free_size[i] = '0;
		count_setting = COUNT_RESET;
		mismatches    = 0;
		items_sent    = 0;
		n_loaded      = 0;
		n_allocated   = 0;
		n_no_fit      = 0;
		config_writes = 0;
		src_idle_pct  = 16;
		sink_idle_pct = 85;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners, sender light / receiver heavy idling
		test_empty_table();
		test_field_extremes();
		test_best_fit_ties();
		test_count_limits();
		test_load_beyond_count();

		// phase 1: sender idles little, receiver a lot
		test_random_traffic(120);
		set_block_count(5'd31);
		test_random_traffic(50);
		test_output_backpressure();

		// phase 2: roles swapped
		src_idle_pct  = 85;
		sink_idle_pct = 16;
		set_block_count(COUNT_W'($urandom_range(1, NUM_BLOCKS-1)));
		test_random_traffic(100);
		test_drain_pause();
		set_block_count(5'd0);
		test_random_traffic(20);

		// phase 3: no idling on either side
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		set_block_count(5'd8);
		test_random_traffic(100);
		set_block_count(5'd1);
		test_random_traffic(40);
		set_block_count(5'd16);
		test_random_traffic(60);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d transactions: %0d loads, %0d allocations, %0d without fit,",
			items_sent, n_loaded, n_allocated, n_no_fit);
		$display("over %0d block_count writes and three idle patterns; %0d mismatches.",
			config_writes, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
src/bfba_pkg.sv
src/bfba_if.sv
src/bfba_ram.sv
src/bfba_ctrl.sv
src/bfba_dp.sv
src/best_fit_block_allocator.sv
tb/tb_best_fit_block_allocator.sv
